>>> rtl/tspm_pkg.sv
// tspm_pkg: shared types, codes and constants of the tip supervisor and power meter
// depends on nothing; used by tip_supervisor_power_meter through scoped names

package tspm_pkg;

    // defaults of the top-level parameters
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int BAR_CELLS_DEF   = 14;
    localparam int CELL_STEPS_DEF  = 5;

    // item kinds carried in the input tuser
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_TIP  = 2'd1;
    localparam logic [1:0] ACT_MEAS = 2'd2;
    localparam int ACTION_W = 2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 28;
    localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_DELAY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_THRESHOLD = 2'd1;

    // configuration widths and reset values
    localparam int DELAY_W = 16;
    localparam int THR_W   = 28;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;
    localparam logic [THR_W-1:0]   THR_RESET   = 28'd400000;

    // power arithmetic
    localparam int POWER_SCALE = 165;
    localparam int SCALE_W     = 8;
    localparam int POWER_W     = 28;
    localparam logic [POWER_W-1:0] POWER_MAX = 28'hFFFFFFF;
    localparam int DIGIT_LSB   = 20;
    localparam int DIGIT_W     = 8;

    // bar level q = floor(P*BAR_NUM / (BAR_DEN * 2^DIGIT_LSB)), found one bit a cycle
    localparam int BAR_NUM   = 7;
    localparam int BAR_DEN   = 9;
    localparam int QUOT_BITS = 8;
    localparam int REM_W     = POWER_W + 3;
    localparam int CELL_BITS = 3;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_SAT  = 7'b0000100,
        ST_CMP  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_BAR  = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    // tip supervision modes
    typedef enum logic [2:0] {
        MODE_DISABLED = 3'b001,
        MODE_COUNTING = 3'b010,
        MODE_RUNNING  = 3'b100
    } t_tip_mode;

endpackage

>>> rtl/tip_supervisor_power_meter.sv
// tip_supervisor_power_meter: tip supervision, startup countdown and bit-serial power meter
// depends on tspm_pkg (codes, widths, sequencer and mode enums)

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+--------------------------------------
// s        | in        | i_s_tvalid / o_s_tready | tuser action; tdata level, samples
// m        | out       | o_m_tvalid / i_m_tready | tuser valid, failed; tdata results
// cfg      | in        | i_cfg_valid/o_cfg_ready | register index, write data
//
// tick, tip level and failed measurements pass through ST_DONE to the output register.
// a running measurement goes through ST_MUL, ST_SAT, ST_CMP, ST_DIV, ST_BAR, ST_DONE:
// the product is built one voltage bit a cycle, the bar level one quotient bit a cycle,
// and the bar graph one cell a cycle.
// synchronous active-low reset restores the register defaults and disables the tip.
// a new item is taken while a finished result waits in the output register.

module tip_supervisor_power_meter #(
    parameter int SAMPLE_BITS = tspm_pkg::SAMPLE_BITS_DEF,
    parameter int BAR_CELLS   = tspm_pkg::BAR_CELLS_DEF,
    parameter int CELL_STEPS  = tspm_pkg::CELL_STEPS_DEF,
    localparam int IN_DATA_W  = ((1 + 2 * SAMPLE_BITS) + 7) / 8 * 8,
    localparam int OUT_DATA_W = ((2 + tspm_pkg::DIGIT_W
                                  + tspm_pkg::CELL_BITS * BAR_CELLS) + 7) / 8 * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [IN_DATA_W-1:0]             i_s_tdata,   // tip_level, current, voltage
    input  logic [tspm_pkg::ACTION_W-1:0]    i_s_tuser,   // action
    // results
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [OUT_DATA_W-1:0]            o_m_tdata,   // gen_enable, rising, digits, bars
    output logic [1:0]                       o_m_tuser,   // measurement_valid, tip_failed
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tspm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tspm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int MC_W      = SAMPLE_BITS + tspm_pkg::SCALE_W;
    localparam int PW        = 2 * SAMPLE_BITS + tspm_pkg::SCALE_W;
    localparam int EXT_W     = (PW > tspm_pkg::POWER_W) ? PW : tspm_pkg::POWER_W;
    localparam int BAR_W     = tspm_pkg::CELL_BITS * BAR_CELLS;
    localparam int FIELD_W   = 2 + tspm_pkg::DIGIT_W + BAR_W;
    localparam int MAX_STEPS = (SAMPLE_BITS > BAR_CELLS)
                               ? ((SAMPLE_BITS > tspm_pkg::QUOT_BITS)
                                  ? SAMPLE_BITS : tspm_pkg::QUOT_BITS)
                               : ((BAR_CELLS > tspm_pkg::QUOT_BITS)
                                  ? BAR_CELLS : tspm_pkg::QUOT_BITS);
    localparam int CNT_W     = $clog2(MAX_STEPS);
    localparam int SUM_W     = tspm_pkg::POWER_W + 1;
    localparam int REM_W     = tspm_pkg::REM_W;
    localparam int QB        = tspm_pkg::QUOT_BITS;
    localparam logic [REM_W-1:0] DIV_INIT =
        REM_W'(tspm_pkg::BAR_DEN) << (tspm_pkg::DIGIT_LSB + QB - 1);

    // control registers
    tspm_pkg::t_state    r_state, n_state;
    tspm_pkg::t_tip_mode r_mode, n_mode;
    logic [tspm_pkg::DELAY_W-1:0] r_count, n_count;
    logic [tspm_pkg::DELAY_W-1:0] r_delay;
    logic [tspm_pkg::THR_W-1:0]   r_thr;
    logic [tspm_pkg::POWER_W-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_res_valid, n_res_valid;
    logic                         r_res_fail, n_res_fail;
    logic                         r_out_valid, n_out_valid;

    // datapath registers
    logic [MC_W-1:0]              r_mcand, n_mcand;
    logic [SAMPLE_BITS-1:0]       r_mplier, n_mplier;
    logic [PW-1:0]                r_acc, n_acc;
    logic [tspm_pkg::POWER_W-1:0] r_power, n_power;
    logic [REM_W-1:0]             r_rem, n_rem;
    logic [REM_W-1:0]             r_div, n_div;
    logic [QB-1:0]                r_q, n_q;
    logic [QB-1:0]                r_t, n_t;
    logic [BAR_W-1:0]             r_bar, n_bar;
    logic                         r_rising, n_rising;
    logic [tspm_pkg::DIGIT_W-1:0] r_digits, n_digits;
    logic [OUT_DATA_W-1:0]        r_out_data, n_out_data;
    logic [1:0]                   r_out_user, n_out_user;

    // input fields
    logic [tspm_pkg::ACTION_W-1:0] s_action;
    logic                          s_level;
    logic [SAMPLE_BITS-1:0]        s_current;
    logic [SAMPLE_BITS-1:0]        s_voltage;
    logic                          s_xfer;

    // step helpers
    logic [EXT_W-1:0]             acc_ext;
    logic                         quot_bit;
    logic [tspm_pkg::CELL_BITS-1:0] bar_cell;
    logic                         t_above;
    logic                         out_free;

    assign s_action  = i_s_tuser;
    assign s_level   = i_s_tdata[0];
    assign s_current = i_s_tdata[SAMPLE_BITS:1];
    assign s_voltage = i_s_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1];

    assign o_s_tready  = (r_state == tspm_pkg::ST_IDLE);
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    assign acc_ext  = EXT_W'(r_acc);
    assign quot_bit = (r_rem >= r_div);
    assign t_above  = (r_t > QB'(CELL_STEPS));
    assign bar_cell = t_above ? tspm_pkg::CELL_BITS'(CELL_STEPS)
                              : r_t[tspm_pkg::CELL_BITS-1:0];
    assign out_free = !r_out_valid || i_m_tready;

    // sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_prev      = r_prev;
        n_cnt       = r_cnt;
        n_res_valid = r_res_valid;
        n_res_fail  = r_res_fail;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_acc       = r_acc;
        n_power     = r_power;
        n_rem       = r_rem;
        n_div       = r_div;
        n_q         = r_q;
        n_t         = r_t;
        n_bar       = r_bar;
        n_rising    = r_rising;
        n_digits    = r_digits;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_valid = r_out_valid;

        // result leaves the output register
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tspm_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    n_res_valid = 1'b0;
                    n_res_fail  = 1'b0;
                    n_state     = tspm_pkg::ST_DONE;
                    n_cnt       = '0;
                    case (s_action)
                        tspm_pkg::ACT_TIP: begin
                            if (!s_level) begin
                                n_mode  = tspm_pkg::MODE_DISABLED;
                                n_count = '0;
                            end else if (r_mode != tspm_pkg::MODE_COUNTING &&
                                         r_mode != tspm_pkg::MODE_RUNNING) begin
                                n_mode  = tspm_pkg::MODE_COUNTING;
                                n_count = r_delay;
                            end
                        end
                        tspm_pkg::ACT_TICK: begin
                            if (r_mode == tspm_pkg::MODE_COUNTING) begin
                                if (r_count <= tspm_pkg::DELAY_W'(1)) begin
                                    n_count = '0;
                                    n_mode  = tspm_pkg::MODE_RUNNING;
                                end else begin
                                    n_count = r_count - tspm_pkg::DELAY_W'(1);
                                end
                            end
                        end
                        tspm_pkg::ACT_MEAS: begin
                            if (r_mode == tspm_pkg::MODE_RUNNING) begin
                                // current times the scale, voltage shifted out msb first
                                n_res_valid = 1'b1;
                                n_mcand     = MC_W'(s_current) *
                                              MC_W'(tspm_pkg::POWER_SCALE);
                                n_mplier    = s_voltage;
                                n_acc       = '0;
                                n_state     = tspm_pkg::ST_MUL;
                            end else begin
                                n_res_fail = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // shift-add multiply, one voltage bit a cycle
            tspm_pkg::ST_MUL: begin
                n_acc    = (r_acc << 1) + (r_mplier[SAMPLE_BITS-1] ? PW'(r_mcand) : '0);
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SAMPLE_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = tspm_pkg::ST_SAT;
                end
            end

            // clamp the product to the power width
            tspm_pkg::ST_SAT: begin
                n_power = (acc_ext > EXT_W'(tspm_pkg::POWER_MAX))
                          ? tspm_pkg::POWER_MAX
                          : tspm_pkg::POWER_W'(acc_ext);
                n_state = tspm_pkg::ST_CMP;
            end

            // rise flag, digits and divider setup
            tspm_pkg::ST_CMP: begin
                n_rising = ({1'b0, r_power} > (SUM_W'(r_prev) + SUM_W'(r_thr)));
                n_prev   = r_power;
                n_digits = r_power[tspm_pkg::DIGIT_LSB +: tspm_pkg::DIGIT_W];
                n_rem    = REM_W'(r_power) * REM_W'(tspm_pkg::BAR_NUM);
                n_div    = DIV_INIT;
                n_q      = '0;
                n_state  = tspm_pkg::ST_DIV;
            end

            // restoring division, one quotient bit a cycle
            tspm_pkg::ST_DIV: begin
                if (quot_bit) begin
                    n_rem = r_rem - r_div;
                end
                n_div = r_div >> 1;
                n_q   = {r_q[QB-2:0], quot_bit};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QB - 1)) begin
                    n_cnt   = '0;
                    n_t     = {r_q[QB-2:0], quot_bit};
                    n_state = tspm_pkg::ST_BAR;
                end
            end

            // bar graph, one cell a cycle, cell zero ends at the bottom
            tspm_pkg::ST_BAR: begin
                n_bar = BAR_W'({bar_cell, r_bar} >> tspm_pkg::CELL_BITS);
                n_t   = t_above ? (r_t - QB'(CELL_STEPS)) : '0;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BAR_CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tspm_pkg::ST_DONE;
                end
            end

            // hand the result to the output register
            tspm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = {r_res_fail, r_res_valid};
                    n_out_data  = OUT_DATA_W'({
                        r_res_valid ? r_bar : BAR_W'(0),
                        r_res_valid ? r_digits : tspm_pkg::DIGIT_W'(0),
                        r_res_valid && r_rising,
                        (r_mode == tspm_pkg::MODE_RUNNING)
                    });
                    n_state = tspm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tspm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tspm_pkg::ST_IDLE;
            r_mode      <= tspm_pkg::MODE_DISABLED;
            r_count     <= '0;
            r_prev      <= '0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
            r_res_fail  <= 1'b0;
            r_out_valid <= 1'b0;
            r_delay     <= tspm_pkg::DELAY_RESET;
            r_thr       <= tspm_pkg::THR_RESET;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_prev      <= n_prev;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
            r_res_fail  <= n_res_fail;
            r_out_valid <= n_out_valid;
            // configuration transfer
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tspm_pkg::REG_STARTUP_DELAY: begin
                        r_delay <= i_cfg_data[tspm_pkg::DELAY_W-1:0];
                    end
                    tspm_pkg::REG_RISE_THRESHOLD: begin
                        r_thr <= i_cfg_data[tspm_pkg::THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_acc      <= n_acc;
        r_power    <= n_power;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_q        <= n_q;
        r_t        <= n_t;
        r_bar      <= n_bar;
        r_rising   <= n_rising;
        r_digits   <= n_digits;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

`ifndef SYNTHESIS
    // a running generator has finished its countdown
    a_running_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == tspm_pkg::MODE_RUNNING) |-> (r_count == '0))
        else $error("generator running with countdown pending");

    // a result is never both a valid measurement and a tip failure
    a_valid_fail_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("measurement valid and tip failed together");

    // a valid measurement only comes while the generator runs
    a_valid_needs_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tdata[0])
        else $error("measurement valid with generator off");

    // power fields stay clear unless the measurement is valid
    a_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[FIELD_W-1:1] == '0))
        else $error("power fields set on a non-measurement result");

    // the input stays closed while a measurement is being worked
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(s_xfer && (s_action == tspm_pkg::ACT_MEAS) &&
              (r_mode == tspm_pkg::MODE_RUNNING)) |-> !o_s_tready)
        else $error("input accepted during a measurement");
`endif

endmodule
